FILE: hw/rtl/particle_table_integrator_macros.svh
// assertion macros for the particle table integrator checker
// needs a clk_i and an active-low rst_ni in the scope of each use
`ifndef PARTICLE_TABLE_INTEGRATOR_MACROS_SVH
`define PARTICLE_TABLE_INTEGRATOR_MACROS_SVH

// clocked check, off while reset is held
`define PTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define PTI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/ptab_pkg.sv
// shared types and constants of the particle table integrator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptab_pkg;

  localparam int LANE_W  = 16;
  localparam int VEC_W   = 48;
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // degrees q10.6 to radians q3.12, scaled by 2^24
  localparam logic [24:0] RAD_K = 25'd18740330;

  // divider: dividend width and quotient bits retired per cycle
  localparam int DIV_W     = 40;
  localparam int DIV_DIGIT = 4;
  localparam int DIV_STEPS = DIV_W / DIV_DIGIT;

  typedef enum logic {
    OP_SPAWN = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_UPDATE = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_SPWR,
    S_SCAN,
    S_LOAD,
    S_MUL1,
    S_MUL2,
    S_MULLO,
    S_MULHI,
    S_DIVGO,
    S_DIV,
    S_STORE,
    S_PUSH,
    S_FLUSH
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [15:0]      lifetime_frames;
    logic [VEC_W-1:0] spawn_position;
    logic [VEC_W-1:0] spawn_velocity;
    logic [VEC_W-1:0] spawn_accel;
    logic [VEC_W-1:0] rotation_begin;
    logic [VEC_W-1:0] rotation_final;
    logic [VEC_W-1:0] scale_begin;
    logic [VEC_W-1:0] scale_final;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [3:0]       slot_index;
    logic [VEC_W-1:0] out_position;
    logic [VEC_W-1:0] out_rotation;
    logic [VEC_W-1:0] out_scale;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [15:0]      frame;
    logic [15:0]      life;
    logic [VEC_W-1:0] pos;
    logic [VEC_W-1:0] vel;
    logic [VEC_W-1:0] acc;
    logic [VEC_W-1:0] rot_b;
    logic [VEC_W-1:0] rot_f;
    logic [VEC_W-1:0] scl_b;
    logic [VEC_W-1:0] scl_f;
  } slot_entry_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [15:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ptab_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ptab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ptab_div.sv
// unsigned divider, restoring, four quotient bits per cycle
// depends on ptab_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptab_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ptab_pkg::div_req_t  req_i,
  output ptab_pkg::div_rsp_t       rsp_o
);
  import ptab_pkg::*;

  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [DIV_W-1:0] quo_q, quo_d;
  logic [15:0]      rem_q, rem_d;
  logic [CW-1:0]    cnt_q;
  logic             done_q;

  // one radix-16 digit: four compare-subtract steps
  always_comb begin
    logic [16:0]      r;
    logic [DIV_W-1:0] qv;
    r  = {1'b0, rem_q};
    qv = quo_q;
    for (int j = 0; j < DIV_DIGIT; j++) begin
      r  = {r[15:0], qv[DIV_W-1]};
      qv = {qv[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, req_i.divisor}) begin
        r     = r - {1'b0, req_i.divisor};
        qv[0] = 1'b1;
      end
    end
    quo_d = qv;
    rem_d = r[15:0];
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= CW'(DIV_STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // shift register holding dividend, then quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/particle_table_integrator.sv
// particle table integrator top level: slot table, sequencer, shared multiplier
// depends on ptab_pkg, ptab_ram, ptab_div
//
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+--------------------
// in       | input     | in_valid_i / in_stall_o   | in_item_i (spawn or tick)
// out      | output    | out_valid_o / out_stall_i | out_item_o (report or update)
// cfg      | input     | cfg_we_i                  | cfg_wdata_i (gravity)
//
// a spawn finds its free slot by a one-slot-a-cycle scan
// a tick scans the slots, clears expiring ones and updates live ones through one shared
// 19x26 multiplier and the 4-bit-per-cycle divider, six lanes per slot
// the slot table is one ram; live bits clear at reset, no clearing pass
// a stalled output holds the sequencer only where it has a result to hand over

`timescale 1ns / 1ps
`default_nettype none

module particle_table_integrator #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ptab_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ptab_pkg::out_item_t       out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [47:0]          cfg_wdata_i
);
  import ptab_pkg::*;

  localparam int IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ENT_W = $bits(slot_entry_t);

  // per-lane saturating add of packed vectors
  function automatic logic [VEC_W-1:0] add_sat(input logic [VEC_W-1:0] a,
                                               input logic [VEC_W-1:0] b);
    logic [VEC_W-1:0] r;
    logic [16:0]      s;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      s = {a[k*LANE_W+15], a[k*LANE_W +: LANE_W]} + {b[k*LANE_W+15], b[k*LANE_W +: LANE_W]};
      if (s[16] != s[15]) begin
        r[k*LANE_W +: LANE_W] = s[16] ? 16'h8000 : 16'h7fff;
      end else begin
        r[k*LANE_W +: LANE_W] = s[15:0];
      end
    end
    return r;
  endfunction

  function automatic logic [LANE_W-1:0] lane_get(input logic [VEC_W-1:0] v,
                                                 input logic [1:0] k);
    logic [LANE_W-1:0] r;
    case (k)
      2'd1:    r = v[31:16];
      2'd2:    r = v[47:32];
      default: r = v[15:0];
    endcase
    return r;
  endfunction

  // sign and saturate a rounded magnitude
  function automatic logic [LANE_W-1:0] sat_q(input logic [DIV_W-1:0] q, input logic neg);
    logic [LANE_W-1:0] r;
    if (!neg) begin
      r = (q > DIV_W'(32767)) ? 16'h7fff : q[15:0];
    end else begin
      r = (q > DIV_W'(32768)) ? 16'h8000 : (16'h0 - q[15:0]);
    end
    return r;
  endfunction

  state_e               state_q, state_d;
  logic [IW-1:0]        idx_q;
  logic [SLOT_COUNT-1:0] live_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 out_valid_q, pend_valid_q;
  out_item_t            out_q, pend_q;
  logic [VEC_W-1:0]     grav_q;

  in_item_t             in_q;
  slot_entry_t          ent_q;
  logic [16:0]          f_q;
  logic [1:0]           lane_q;
  logic                 part_q;
  logic signed [35:0]   acc_q;
  logic                 neg_q;
  logic [34:0]          mag_q;
  logic [42:0]          mlo_q;
  logic [DIV_W-1:0]     dvd_q;
  logic [VEC_W-1:0]     rot_q, scl_q;
  logic                 spawn_ok_q;

  // slot table ram
  logic                 ram_we;
  slot_entry_t          ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;
  slot_entry_t          rd_ent;

  ptab_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign rd_ent = slot_entry_t'(ram_rdata);

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.start    = (state_q == S_DIVGO);
  assign div_req.dividend = dvd_q;
  assign div_req.divisor  = ent_q.life;

  ptab_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // common conditions
  logic idx_last, slot_live, out_free, can_emit, push_wait;
  assign idx_last  = (idx_q == IW'(SLOT_COUNT - 1));
  assign slot_live = live_q[idx_q];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign can_emit  = (cnt_q < CNT_W'(MAX_OUT));
  assign push_wait = can_emit && pend_valid_q && !out_free;

  // slot advance on load: frame count, velocity, position
  logic [16:0]      ld_f;
  logic             ld_dead;
  logic [VEC_W-1:0] ld_vel;
  slot_entry_t      ld_ent;
  always_comb begin
    ld_f    = {1'b0, rd_ent.frame} + 17'd1;
    ld_dead = ld_f > {1'b0, rd_ent.life};
    ld_vel  = add_sat(add_sat(rd_ent.vel, rd_ent.acc), grav_q);
    ld_ent       = rd_ent;
    ld_ent.frame = ld_f[15:0];
    ld_ent.vel   = ld_vel;
    ld_ent.pos   = add_sat(rd_ent.pos, ld_vel);
  end

  // shared multiplier and its operand selection
  logic [LANE_W-1:0]  ls, le;
  logic [16:0]        diff;
  logic signed [18:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [44:0] prod;
  always_comb begin
    ls   = lane_get(part_q ? ent_q.scl_b : ent_q.rot_b, lane_q);
    le   = lane_get(part_q ? ent_q.scl_f : ent_q.rot_f, lane_q);
    diff = {le[15], le} - {ls[15], ls};
    unique case (state_q)
      S_MUL2: begin
        mul_a = {{2{diff[16]}}, diff};
        mul_b = {9'b0, f_q};
      end
      S_MULLO: begin
        mul_a = {1'b0, mag_q[17:0]};
        mul_b = {1'b0, RAD_K};
      end
      S_MULHI: begin
        mul_a = {2'b0, mag_q[34:18]};
        mul_b = {1'b0, RAD_K};
      end
      default: begin
        mul_a = {{3{ls[15]}}, ls};
        mul_b = {10'b0, ent_q.life};
      end
    endcase
    prod = mul_a * mul_b;
  end

  // numerator sum and rounding adds
  logic signed [35:0] sum2;
  logic [34:0]        mag_d;
  logic [60:0]        rot_tot;
  logic [LANE_W-1:0]  res16;
  always_comb begin
    sum2    = acc_q + prod[35:0];
    mag_d   = sum2[35] ? 35'(-sum2) : sum2[34:0];
    rot_tot = 61'({prod[41:0], 18'b0}) + 61'(mlo_q) + 61'({ent_q.life, 23'b0});
    res16   = sat_q(div_rsp.quotient, neg_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = (in_item_i.op == OP_SPAWN) ? S_FIND : S_SCAN;
      S_FIND:  if (!slot_live || idx_last) state_d = S_SPWR;
      S_SPWR:  if (out_free) state_d = S_IDLE;
      S_SCAN: begin
        if (slot_live) state_d = S_LOAD;
        else if (idx_last) state_d = S_FLUSH;
      end
      S_LOAD: begin
        if (!ld_dead) state_d = S_MUL1;
        else state_d = idx_last ? S_FLUSH : S_SCAN;
      end
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = part_q ? S_DIVGO : S_MULLO;
      S_MULLO: state_d = S_MULHI;
      S_MULHI: state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIV;
      S_DIV:   if (div_rsp.done) state_d = S_STORE;
      S_STORE: state_d = (lane_q == 2'd2 && part_q) ? S_PUSH : S_MUL1;
      S_PUSH:  if (!push_wait) state_d = idx_last ? S_FLUSH : S_SCAN;
      S_FLUSH: if (!pend_valid_q || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs of the sequencer
  logic      idx_inc, live_set, live_clr, out_load, pend_load;
  out_item_t out_next, upd_item;
  always_comb begin
    idx_inc   = 1'b0;
    live_set  = 1'b0;
    live_clr  = 1'b0;
    out_load  = 1'b0;
    pend_load = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = ld_ent;

    upd_item.kind         = KIND_UPDATE;
    upd_item.slot_index   = 4'(idx_q);
    upd_item.out_position = ent_q.pos;
    upd_item.out_rotation = rot_q;
    upd_item.out_scale    = scl_q;
    upd_item.last         = 1'b0;

    out_next      = pend_q;
    out_next.last = (state_q == S_FLUSH);

    unique case (state_q)
      S_FIND: begin
        if (!slot_live) begin
          live_set        = 1'b1;
          ram_we          = 1'b1;
          ram_wdata.frame = '0;
          ram_wdata.life  = in_q.lifetime_frames;
          ram_wdata.pos   = in_q.spawn_position;
          ram_wdata.vel   = in_q.spawn_velocity;
          ram_wdata.acc   = in_q.spawn_accel;
          ram_wdata.rot_b = in_q.rotation_begin;
          ram_wdata.rot_f = in_q.rotation_final;
          ram_wdata.scl_b = in_q.scale_begin;
          ram_wdata.scl_f = in_q.scale_final;
        end else if (!idx_last) begin
          idx_inc = 1'b1;
        end
      end
      S_SPWR: begin
        out_load              = out_free;
        out_next.kind         = spawn_ok_q ? KIND_ACCEPT : KIND_REJECT;
        out_next.slot_index   = spawn_ok_q ? 4'(idx_q) : 4'd0;
        out_next.out_position = '0;
        out_next.out_rotation = '0;
        out_next.out_scale    = '0;
        out_next.last         = 1'b1;
      end
      S_SCAN: idx_inc = !slot_live && !idx_last;
      S_LOAD: begin
        if (ld_dead) begin
          live_clr = 1'b1;
          idx_inc  = !idx_last;
        end else begin
          ram_we = 1'b1;
        end
      end
      S_PUSH: begin
        if (!push_wait) begin
          idx_inc   = !idx_last;
          pend_load = can_emit;
          out_load  = can_emit && pend_valid_q;
        end
      end
      S_FLUSH: out_load = pend_valid_q && out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      live_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      grav_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        idx_q <= '0;
        cnt_q <= '0;
      end else begin
        if (idx_inc) idx_q <= idx_q + IW'(1);
        if (pend_load) cnt_q <= cnt_q + CNT_W'(1);
      end
      if (live_set) live_q[idx_q] <= 1'b1;
      if (live_clr) live_q[idx_q] <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (pend_load) pend_valid_q <= 1'b1;
      else if (out_load && state_q == S_FLUSH) pend_valid_q <= 1'b0;
      if (cfg_we_i) grav_q <= cfg_wdata_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) in_q <= in_item_i;
    if (state_q == S_FIND) spawn_ok_q <= !slot_live;
    if (out_load) out_q <= out_next;
    if (pend_load) pend_q <= upd_item;
    unique case (state_q)
      S_LOAD: begin
        ent_q  <= ld_ent;
        f_q    <= ld_f;
        lane_q <= 2'd0;
        part_q <= 1'b0;
      end
      S_MUL1: acc_q <= prod[35:0];
      S_MUL2: begin
        neg_q <= sum2[35];
        mag_q <= mag_d;
        dvd_q <= DIV_W'(mag_d) + DIV_W'(ent_q.life[15:1]);
      end
      S_MULLO: mlo_q <= prod[42:0];
      S_MULHI: dvd_q <= DIV_W'(rot_tot[60:24]);
      S_STORE: begin
        for (int k = 0; k < 3; k++) begin
          if (lane_q == 2'(k)) begin
            if (part_q) scl_q[k*LANE_W +: LANE_W] <= res16;
            else rot_q[k*LANE_W +: LANE_W] <= res16;
          end
        end
        if (lane_q == 2'd2) begin
          lane_q <= 2'd0;
          part_q <= 1'b1;
        end else begin
          lane_q <= lane_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ptab_checker.sv
// port-level checks of the particle table integrator, bound to the top level
// depends on ptab_pkg and particle_table_integrator_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "particle_table_integrator_macros.svh"

module ptab_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire ptab_pkg::out_item_t out_item_o
);
  import ptab_pkg::*;

  // a stalled result item holds
  `PTI_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o), "stalled output item changed")

  // an accepted item keeps the block busy for the next cycle
  `PTI_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "input taken again right after an item")

  // spawn reports always close their item
  `PTI_ASSERT(a_spawn_last, out_valid_o && out_item_o.kind != KIND_UPDATE |-> out_item_o.last, "spawn report without last")

  // only defined result kinds appear
  `PTI_ASSERT(a_kind_code, out_valid_o |-> out_item_o.kind != 2'd3, "undefined result kind")

  // nothing is offered while reset is held
  `PTI_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind particle_table_integrator ptab_checker u_ptab_checker (.*);

`default_nettype wire
